/* rtl/core/lwcp_pkg.sv */
// Shared types and constants for the least-interference channel picker.
// No dependencies.
package lwcp_pkg;

  localparam int WEIGHT_W  = 12;
  localparam int CHAN_W    = 8;
  localparam int RSSI_W    = 8;
  localparam int OUT_CH_W  = 4;
  localparam int STRENGTH_W = 7;
  localparam int PROD_W    = STRENGTH_W + WEIGHT_W;
  localparam int FRAC_W    = 8;
  localparam int CONTRIB_W = PROD_W - FRAC_W;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIST_W    = 4;

  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 7'd120;
  localparam logic [OUT_CH_W-1:0] SCORED_A  = 4'd1;
  localparam logic [OUT_CH_W-1:0] SCORED_B  = 4'd6;
  localparam logic [OUT_CH_W-1:0] SCORED_C  = 4'd11;
  localparam logic [CHAN_W-1:0]   CHAN_LOW  = 8'd1;
  localparam logic [CHAN_W-1:0]   CHAN_HIGH = 8'd11;
  localparam logic [DIST_W-1:0]   DIST_MAX  = 4'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_SAME_RST  = 12'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE_RST   = 12'd192;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TWO_RST   = 12'd128;
  localparam logic [WEIGHT_W-1:0] WEIGHT_THREE_RST = 12'd64;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FOUR_RST  = 12'd32;
  localparam logic [OUT_CH_W-1:0] FALLBACK_RST     = 4'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SAME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_OFF_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_OFF_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_OFF_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_OFF_FOUR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK        = 3'd5;

  localparam logic [DIST_W-1:0] DIST_SAME  = 4'd0;
  localparam logic [DIST_W-1:0] DIST_ONE   = 4'd1;
  localparam logic [DIST_W-1:0] DIST_TWO   = 4'd2;
  localparam logic [DIST_W-1:0] DIST_THREE = 4'd3;
  localparam logic [DIST_W-1:0] DIST_FOUR  = 4'd4;

  typedef struct packed {
    logic [WEIGHT_W-1:0] same;
    logic [WEIGHT_W-1:0] off_one;
    logic [WEIGHT_W-1:0] off_two;
    logic [WEIGHT_W-1:0] off_three;
    logic [WEIGHT_W-1:0] off_four;
    logic [OUT_CH_W-1:0] fallback;
  } weights_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [CONTRIB_W-1:0] c_a;
    logic [CONTRIB_W-1:0] c_b;
    logic [CONTRIB_W-1:0] c_c;
  } contrib_t;

  typedef struct packed {
    logic               valid;
    logic [TOTAL_W-1:0] t_a;
    logic [TOTAL_W-1:0] t_b;
    logic [TOTAL_W-1:0] t_c;
  } snap_t;

endpackage

/* rtl/core/lwcp_if.sv */
// Handshake channel interfaces: scan items, results, configuration writes.
// Depends on lwcp_pkg.
interface lwcp_item_if;
  logic                        valid;
  logic                        ready;
  logic                        has_network;
  logic [lwcp_pkg::CHAN_W-1:0] chan_number;
  logic signed [lwcp_pkg::RSSI_W-1:0] rssi_dbm;
  logic                        last_report;

  modport source (output valid, has_network, chan_number, rssi_dbm, last_report,
                  input ready);
  modport sink (input valid, has_network, chan_number, rssi_dbm, last_report,
                output ready);
endinterface

interface lwcp_result_if;
  logic                          valid;
  logic                          ready;
  logic [lwcp_pkg::OUT_CH_W-1:0] best_channel;
  logic                          used_fallback;

  modport source (output valid, best_channel, used_fallback, input ready);
  modport sink (input valid, best_channel, used_fallback, output ready);
endinterface

interface lwcp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lwcp_pkg::CFG_IDX_W-1:0]  index;
  logic [lwcp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/lwcp_cfg.sv */
// Configuration register file: five distance weights and the fallback channel.
// Depends on lwcp_pkg, lwcp_cfg_if.
module lwcp_cfg (
  input  logic              clk,
  input  logic              rst,
  lwcp_cfg_if.sink          cfg,
  output lwcp_pkg::weights_t weights
);
  import lwcp_pkg::*;

  weights_t regs;

  assign cfg.ready = 1'b1;
  assign weights   = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.same      <= WEIGHT_SAME_RST;
      regs.off_one   <= WEIGHT_ONE_RST;
      regs.off_two   <= WEIGHT_TWO_RST;
      regs.off_three <= WEIGHT_THREE_RST;
      regs.off_four  <= WEIGHT_FOUR_RST;
      regs.fallback  <= FALLBACK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WEIGHT_SAME:      regs.same      <= cfg.data;
        CFG_WEIGHT_OFF_ONE:   regs.off_one   <= cfg.data;
        CFG_WEIGHT_OFF_TWO:   regs.off_two   <= cfg.data;
        CFG_WEIGHT_OFF_THREE: regs.off_three <= cfg.data;
        CFG_WEIGHT_OFF_FOUR:  regs.off_four  <= cfg.data;
        CFG_FALLBACK:         regs.fallback  <= cfg.data[OUT_CH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/lwcp_contrib.sv */
// Input register and weighted-strength stage: three contributions per item.
// Depends on lwcp_pkg, lwcp_item_if.
module lwcp_contrib (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  lwcp_item_if.sink          items,
  input  lwcp_pkg::weights_t weights,
  output lwcp_pkg::contrib_t contrib
);
  import lwcp_pkg::*;

  logic                     in_valid;
  logic                     in_has;
  logic [CHAN_W-1:0]        in_chan;
  logic signed [RSSI_W-1:0] in_rssi;
  logic                     in_last;

  logic                     in_scored;
  logic signed [RSSI_W:0]   sum;
  logic [STRENGTH_W-1:0]    strength;
  logic [OUT_CH_W-1:0]      chan4;
  logic [CONTRIB_W-1:0]     c_a_next;
  logic [CONTRIB_W-1:0]     c_b_next;
  logic [CONTRIB_W-1:0]     c_c_next;
  contrib_t                 stage;

  function automatic logic [CONTRIB_W-1:0] weigh(
    input logic [OUT_CH_W-1:0]   ch,
    input logic [OUT_CH_W-1:0]   scored,
    input logic [STRENGTH_W-1:0] s,
    input weights_t              w
  );
    logic [DIST_W-1:0]   d;
    logic [WEIGHT_W-1:0] wt;
    logic [PROD_W-1:0]   p;
    d = (ch > scored) ? (ch - scored) : (scored - ch);
    unique case (d)
      DIST_SAME:  wt = w.same;
      DIST_ONE:   wt = w.off_one;
      DIST_TWO:   wt = w.off_two;
      DIST_THREE: wt = w.off_three;
      DIST_FOUR:  wt = w.off_four;
      default:    wt = '0;
    endcase
    p = PROD_W'(s) * PROD_W'(wt);
    return p[PROD_W-1:FRAC_W];
  endfunction

  assign items.ready = adv;
  assign contrib     = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_has  <= items.has_network;
      in_chan <= items.chan_number;
      in_rssi <= items.rssi_dbm;
      in_last <= items.last_report;
    end
  end

  always_comb begin
    in_scored = in_has && (in_chan >= CHAN_LOW) && (in_chan <= CHAN_HIGH);
    sum = {in_rssi[RSSI_W-1], in_rssi} + (RSSI_W+1)'(signed'({2'b00, STRENGTH_MAX}));
    if (sum < 0) begin
      strength = '0;
    end else if (sum > (RSSI_W+1)'(signed'({2'b00, STRENGTH_MAX}))) begin
      strength = STRENGTH_MAX;
    end else begin
      strength = sum[STRENGTH_W-1:0];
    end
    chan4 = in_chan[OUT_CH_W-1:0];
    if (in_scored) begin
      c_a_next = weigh(chan4, SCORED_A, strength, weights);
      c_b_next = weigh(chan4, SCORED_B, strength, weights);
      c_c_next = weigh(chan4, SCORED_C, strength, weights);
    end else begin
      c_a_next = '0;
      c_b_next = '0;
      c_c_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage.last <= in_last;
      stage.c_a  <= c_a_next;
      stage.c_b  <= c_b_next;
      stage.c_c  <= c_c_next;
    end
  end

endmodule

/* rtl/core/lwcp_accum.sv */
// Saturating interference totals; snapshot and clear on the last report.
// Depends on lwcp_pkg.
module lwcp_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  lwcp_pkg::contrib_t contrib,
  output lwcp_pkg::snap_t    snap
);
  import lwcp_pkg::*;

  logic [TOTAL_W-1:0] total_a;
  logic [TOTAL_W-1:0] total_b;
  logic [TOTAL_W-1:0] total_c;
  logic [TOTAL_W-1:0] total_a_next;
  logic [TOTAL_W-1:0] total_b_next;
  logic [TOTAL_W-1:0] total_c_next;
  snap_t              hold;

  function automatic logic [TOTAL_W-1:0] sat_add(
    input logic [TOTAL_W-1:0]   t,
    input logic [CONTRIB_W-1:0] c
  );
    logic [TOTAL_W:0] s;
    s = {1'b0, t} + (TOTAL_W+1)'(c);
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  assign snap = hold;

  always_comb begin
    total_a_next = sat_add(total_a, contrib.c_a);
    total_b_next = sat_add(total_b, contrib.c_b);
    total_c_next = sat_add(total_c, contrib.c_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_a    <= '0;
      total_b    <= '0;
      total_c    <= '0;
      hold.valid <= 1'b0;
    end else if (adv) begin
      hold.valid <= contrib.valid && contrib.last;
      if (contrib.valid && contrib.last) begin
        total_a <= '0;
        total_b <= '0;
        total_c <= '0;
      end else if (contrib.valid) begin
        total_a <= total_a_next;
        total_b <= total_b_next;
        total_c <= total_c_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hold.t_a <= total_a_next;
      hold.t_b <= total_b_next;
      hold.t_c <= total_c_next;
    end
  end

endmodule

/* rtl/core/lwcp_decide.sv */
// Strict-minimum channel decision and the result output register.
// Depends on lwcp_pkg, lwcp_result_if.
module lwcp_decide (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  lwcp_pkg::snap_t    snap,
  input  lwcp_pkg::weights_t weights,
  lwcp_result_if.source      results
);
  import lwcp_pkg::*;

  logic                valid;
  logic [OUT_CH_W-1:0] best;
  logic                fb;
  logic [OUT_CH_W-1:0] best_next;
  logic                fb_next;

  assign results.valid         = valid;
  assign results.best_channel  = best;
  assign results.used_fallback = fb;

  always_comb begin
    fb_next = 1'b0;
    priority if (snap.t_a < snap.t_b && snap.t_a < snap.t_c) begin
      best_next = SCORED_A;
    end else if (snap.t_b < snap.t_a && snap.t_b < snap.t_c) begin
      best_next = SCORED_B;
    end else if (snap.t_c < snap.t_a && snap.t_c < snap.t_b) begin
      best_next = SCORED_C;
    end else begin
      best_next = weights.fallback;
      fb_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= snap.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      best <= best_next;
      fb   <= fb_next;
    end
  end

endmodule

/* rtl/core/wlan_least_interference_channel_pick.sv */
// Least-interference channel picker for 2.4 GHz scans, top level.
// Uses lwcp_pkg, lwcp_if, lwcp_cfg, lwcp_contrib, lwcp_accum, lwcp_decide.
//
// items:   one scan report per item (has_network, chan_number, rssi_dbm,
//          last_report). One item is taken every cycle while the path moves.
// results: one item per scan, sent for the report with last_report set:
//          best_channel (1, 6, 11 or fallback) and used_fallback.
// cfg:     register writes (index 0..5), always ready; the user must write
//          them only while idle, which the block itself does not enforce.
// Pipeline: input register, weight/multiply register, totals with snapshot,
// result register, which a report passes in order. Throughput is one item
// per cycle while results is not stalled; the three totals update once per
// item and are cleared as the last report of a scan is folded in.
// When results is stalled the whole pipeline holds and items.ready drops;
// while a result waits, items.ready follows results.ready.
// Reset (rst, synchronous) empties the pipeline, clears the totals and loads
// the default weights and fallback channel.
module wlan_least_interference_channel_pick (
  input  logic           clk,
  input  logic           rst,
  lwcp_item_if.sink      items,
  lwcp_result_if.source  results,
  lwcp_cfg_if.sink       cfg
);
  import lwcp_pkg::*;

  logic     adv;
  weights_t weights;
  contrib_t contrib;
  snap_t    snap;

  assign adv = !results.valid || results.ready;

  lwcp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .weights (weights)
  );

  lwcp_contrib u_contrib (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .items   (items),
    .weights (weights),
    .contrib (contrib)
  );

  lwcp_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .contrib (contrib),
    .snap    (snap)
  );

  lwcp_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .snap    (snap),
    .weights (weights),
    .results (results)
  );

endmodule
